FILE: src/shsa_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers of the Hessian scatter accumulator
package shsa_pkg;

   localparam int MAX_DEGREE = 4;
   localparam int MAX_KNOTS  = 16;

   localparam int DATA_W    = 64;
   localparam int DEG_W     = 3;
   localparam int KNOT_W    = 5;
   localparam int START_W   = 4;
   localparam int RC_W      = 7;
   localparam int REQ_W     = 3;
   localparam int CSR_W     = 5;
   localparam int CSR_IDX_W = 2;

   localparam int GSTRIDE    = 6 * MAX_KNOTS;
   localparam int HESS_DEPTH = GSTRIDE * GSTRIDE;
   localparam int HADDR_W    = $clog2(HESS_DEPTH);
   localparam int GADDR_W    = $clog2(GSTRIDE);
   localparam int MAX_N      = 6 * MAX_DEGREE;
   localparam int TRI_W      = $clog2(MAX_N + 1);
   localparam int MAX_FRAME  = (MAX_N + 1) * (MAX_N + 2) / 2;
   localparam int POS_W      = $clog2(MAX_FRAME + 1);
   localparam int KD_W       = $clog2(MAX_DEGREE + 1);
   localparam int KN_W       = $clog2(MAX_KNOTS + 1);
   localparam int G_W        = $clog2(GSTRIDE + 1);
   localparam int START_MAX  = (1 << START_W) - 1;
   localparam int GI_W       = $clog2(3 * (MAX_KNOTS + START_MAX + MAX_DEGREE));

   localparam logic [DEG_W-1:0]  DEGREE_RESET = 3'd1;
   localparam logic [KNOT_W-1:0] KNOTS_RESET  = 5'd16;

   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

   typedef enum logic [REQ_W-1:0] {
      REQ_CLEAR     = 3'd0,
      REQ_ACCUM     = 3'd1,
      REQ_READ_HESS = 3'd2,
      REQ_READ_GRAD = 3'd3,
      REQ_READ_COST = 3'd4
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEGREE    = 2'd0,
      CSR_KNOTS     = 2'd1,
      CSR_COST_ONLY = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_CLEAR,
      ACT_READ,
      ACT_RMW
   } action_type;

   typedef enum logic [1:0] {
      RSRC_ZERO,
      RSRC_MEM,
      RSRC_COST
   } rsp_source_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_RD_RSP,
      ST_RESP,
      ST_RD_A,
      ST_WR_A,
      ST_WR_B
   } ctrl_state_type;

   typedef struct packed {
      logic [REQ_W-1:0]         req_type;
      logic signed [DATA_W-1:0] word_value;
      logic [START_W-1:0]       start_knot;
      logic [RC_W-1:0]          read_row;
      logic [RC_W-1:0]          read_col;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic                     saturated;
      logic                     index_error;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic clear_init;
      logic clear_step;
      logic rd_b;
      logic write_a;
      logic write_b;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type act;
      logic       dual;
      logic       clear_done;
   } dp_status_type;

   typedef struct packed {
      logic [DATA_W-1:0] sum;
      logic              ovf;
   } sat_sum_type;

   function automatic logic [KD_W-1:0] eff_degree(input logic [DEG_W-1:0] deg);
      logic [KD_W-1:0] k;
      if (deg == '0) begin
         k = KD_W'(1);
      end else if (int'(deg) > MAX_DEGREE) begin
         k = KD_W'(MAX_DEGREE);
      end else begin
         k = KD_W'(deg);
      end
      return k;
   endfunction

   function automatic logic [KN_W-1:0] eff_knots(input logic [KNOT_W-1:0] knots);
      logic [KN_W-1:0] kn;
      if (knots == '0) begin
         kn = KN_W'(1);
      end else if (int'(knots) > MAX_KNOTS) begin
         kn = KN_W'(MAX_KNOTS);
      end else begin
         kn = KN_W'(knots);
      end
      return kn;
   endfunction

   // words in one frame: cost, n gradient words, n(n+1)/2 triangle words
   function automatic logic [POS_W-1:0] frame_len(input logic [TRI_W-1:0] n);
      return POS_W'(((int'(n) + 1) * (int'(n) + 2)) / 2);
   endfunction

   // local parameter index to global index; translation half then rotation half
   function automatic logic [GI_W-1:0] map_index(input logic [TRI_W-1:0]   j,
                                                 input logic [KD_W-1:0]    k,
                                                 input logic [KN_W-1:0]    kn,
                                                 input logic [START_W-1:0] start);
      int h;
      int v;
      h = 3 * int'(k);
      if (int'(j) < h) begin
         v = 3 * int'(start) + int'(j);
      end else begin
         v = 3 * (int'(kn) + int'(start)) + int'(j) - h;
      end
      return GI_W'(v);
   endfunction

   function automatic sat_sum_type sat_add(input logic [DATA_W-1:0] a,
                                           input logic [DATA_W-1:0] b);
      sat_sum_type r;
      logic [DATA_W-1:0] s;
      s     = a + b;
      r.ovf = (a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1]);
      if (r.ovf) begin
         r.sum = a[DATA_W-1] ? DATA_MIN : DATA_MAX;
      end else begin
         r.sum = s;
      end
      return r;
   endfunction

endpackage

FILE: src/shsa_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port RAM with registered read data
module shsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/shsa_ctrl.sv
`timescale 1ns / 1ps
// controller state machine: sequences clearing, decode, read-modify-write and responses
module shsa_ctrl import shsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            case (status.act)
               ACT_CLEAR: begin
                  cmd.clear_init = 1'b1;
                  state_in       = ST_CLEAR;
               end
               ACT_READ: begin
                  state_in = ST_RD_RSP;
               end
               ACT_RMW: begin
                  state_in = ST_RD_A;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_RD_RSP: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_RD_A: begin
            state_in = ST_WR_A;
         end
         ST_WR_A: begin
            // mirror entry is read while the first one is written back
            cmd.write_a = 1'b1;
            cmd.rd_b    = 1'b1;
            state_in    = status.dual ? ST_WR_B : ST_IDLE;
         end
         ST_WR_B: begin
            cmd.write_b = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: src/shsa_dp.sv
`timescale 1ns / 1ps
// datapath: config registers, frame position mapping, stores and saturating adder
module shsa_dp import shsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  req_item_type         req_item,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   output rsp_item_type         rsp_item
);

   // configuration
   logic [DEG_W-1:0]  deg_ff, deg_in;
   logic [KNOT_W-1:0] knots_ff, knots_in;
   logic              cost_only_ff, cost_only_in;

   // frame and accumulation state
   req_item_type      req_ff, req_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [TRI_W-1:0]  row_ff, row_in;
   logic [TRI_W-1:0]  col_ff, col_in;
   logic [DATA_W-1:0] cost_ff, cost_in;
   logic              sat_ff, sat_in;
   logic              range_ff, range_in;
   logic [HADDR_W-1:0] clr_ff, clr_in;

   // planned memory operation
   logic [HADDR_W-1:0] addr_a_ff, addr_a_in;
   logic [HADDR_W-1:0] addr_b_ff, addr_b_in;
   logic               tgt_hess_ff, tgt_hess_in;
   logic               dual_ff, dual_in;
   rsp_source_type     rsrc_ff, rsrc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   // decode of the held transaction
   logic [KD_W-1:0]    k;
   logic [KN_W-1:0]    kn;
   logic [TRI_W-1:0]   n;
   logic [G_W-1:0]     g;
   logic [POS_W-1:0]   flen;
   logic [POS_W-1:0]   pos0;
   logic [POS_W-1:0]   pos_inc;
   logic [POS_W-1:0]   pos_nx;
   logic [TRI_W-1:0]   col_inc;
   logic [TRI_W-1:0]   row_nx;
   logic [TRI_W-1:0]   col_nx;
   logic [GI_W-1:0]    gi;
   logic [GI_W-1:0]    gr;
   logic [GI_W-1:0]    gc;
   action_type         act;
   logic               p_cost;
   logic               p_pos;
   logic               p_tri;
   logic               p_range;
   logic [HADDR_W-1:0] p_addr_a;
   logic [HADDR_W-1:0] p_addr_b;
   logic               p_hess;
   logic               p_dual;
   rsp_source_type     p_rsrc;

   sat_sum_type        cost_add;
   sat_sum_type        mem_add;
   logic [DATA_W-1:0]  hess_rd;
   logic [DATA_W-1:0]  grad_rd;
   logic [DATA_W-1:0]  mem_rd;
   logic               hess_we;
   logic [HADDR_W-1:0] hess_waddr;
   logic [HADDR_W-1:0] hess_raddr;
   logic               grad_we;
   logic [GADDR_W-1:0] grad_waddr;
   logic [DATA_W-1:0]  mem_wdata;

   always_comb begin
      k    = eff_degree(deg_ff);
      kn   = eff_knots(knots_ff);
      n    = TRI_W'(6 * int'(k));
      g    = G_W'(6 * int'(kn));
      flen = frame_len(n);

      // a position left past the frame end by a degree change restarts the frame
      pos0    = (pos_ff >= flen) ? '0 : pos_ff;
      pos_inc = pos0 + 1'b1;
      pos_nx  = (pos_inc >= flen) ? '0 : pos_inc;

      // triangle counters saturate at MAX_N: beyond that every value acts alike
      col_inc = (int'(col_ff) >= MAX_N) ? TRI_W'(MAX_N) : TRI_W'(col_ff + 1'b1);
      if (col_inc >= n) begin
         row_nx = (int'(row_ff) >= MAX_N) ? TRI_W'(MAX_N) : TRI_W'(row_ff + 1'b1);
         col_nx = row_nx;
      end else begin
         row_nx = row_ff;
         col_nx = col_inc;
      end

      gi = map_index(TRI_W'(pos0 - 1'b1), k, kn, req_ff.start_knot);
      gr = map_index(row_ff, k, kn, req_ff.start_knot);
      gc = map_index(col_ff, k, kn, req_ff.start_knot);

      act      = ACT_NONE;
      p_cost   = 1'b0;
      p_pos    = 1'b0;
      p_tri    = 1'b0;
      p_range  = 1'b0;
      p_addr_a = '0;
      p_addr_b = '0;
      p_hess   = 1'b0;
      p_dual   = 1'b0;
      p_rsrc   = RSRC_ZERO;

      case (req_ff.req_type)
         REQ_CLEAR: begin
            act = ACT_CLEAR;
         end
         REQ_ACCUM: begin
            p_pos = 1'b1;
            if (pos0 == '0) begin
               p_cost = 1'b1;
            end else if (pos0 <= POS_W'(n)) begin
               if (!cost_only_ff) begin
                  if (int'(gi) < int'(g)) begin
                     act      = ACT_RMW;
                     p_addr_a = HADDR_W'(gi);
                  end else begin
                     p_range = 1'b1;
                  end
               end
            end else begin
               p_tri = 1'b1;
               if (!cost_only_ff) begin
                  if (row_ff >= n || col_ff >= n) begin
                     p_range = 1'b1;
                  end else if (int'(gr) < int'(g) && int'(gc) < int'(g)) begin
                     act      = ACT_RMW;
                     p_hess   = 1'b1;
                     p_dual   = (gr != gc);
                     p_addr_a = HADDR_W'(int'(gr) * GSTRIDE + int'(gc));
                     p_addr_b = HADDR_W'(int'(gc) * GSTRIDE + int'(gr));
                  end else begin
                     p_range = 1'b1;
                  end
               end
            end
         end
         REQ_READ_HESS: begin
            act    = ACT_READ;
            p_hess = 1'b1;
            if (int'(req_ff.read_row) < int'(g) && int'(req_ff.read_col) < int'(g)) begin
               p_rsrc   = RSRC_MEM;
               p_addr_a = HADDR_W'(int'(req_ff.read_row) * GSTRIDE
                                   + int'(req_ff.read_col));
            end
         end
         REQ_READ_GRAD: begin
            act = ACT_READ;
            if (int'(req_ff.read_row) < int'(g)) begin
               p_rsrc   = RSRC_MEM;
               p_addr_a = HADDR_W'(req_ff.read_row);
            end
         end
         REQ_READ_COST: begin
            act    = ACT_READ;
            p_rsrc = RSRC_COST;
         end
         default: begin
            act = ACT_NONE;
         end
      endcase
   end

   assign cost_add = sat_add(cost_ff, req_ff.word_value);
   assign mem_rd   = tgt_hess_ff ? hess_rd : grad_rd;
   assign mem_add  = sat_add(mem_rd, req_ff.word_value);

   always_comb begin
      deg_in       = deg_ff;
      knots_in     = knots_ff;
      cost_only_in = cost_only_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEGREE:    deg_in       = csr_wdata[DEG_W-1:0];
            CSR_KNOTS:     knots_in     = csr_wdata[KNOT_W-1:0];
            CSR_COST_ONLY: cost_only_in = csr_wdata[0];
            default:       deg_in       = deg_ff;
         endcase
      end
   end

   always_comb begin
      req_in       = req_ff;
      pos_in       = pos_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cost_in      = cost_ff;
      sat_in       = sat_ff;
      range_in     = range_ff;
      clr_in       = clr_ff;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      tgt_hess_in  = tgt_hess_ff;
      dual_in      = dual_ff;
      rsrc_in      = rsrc_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;

      if (cmd.load) begin
         req_in = req_item;
      end

      if (cmd.decode) begin
         addr_a_in   = p_addr_a;
         addr_b_in   = p_addr_b;
         tgt_hess_in = p_hess;
         dual_in     = p_dual;
         rsrc_in     = p_rsrc;
         if (p_pos) begin
            pos_in = pos_nx;
         end
         if (p_cost) begin
            cost_in = cost_add.sum;
            sat_in  = sat_ff | cost_add.ovf;
            row_in  = '0;
            col_in  = '0;
         end
         if (p_tri) begin
            row_in = row_nx;
            col_in = col_nx;
         end
         if (p_range) begin
            range_in = 1'b1;
         end
      end

      if (cmd.clear_init) begin
         pos_in   = '0;
         row_in   = '0;
         col_in   = '0;
         cost_in  = '0;
         sat_in   = 1'b0;
         range_in = 1'b0;
         clr_in   = '0;
      end

      if (cmd.clear_step) begin
         clr_in = clr_ff + 1'b1;
      end

      if (cmd.write_a || cmd.write_b) begin
         sat_in = sat_ff | mem_add.ovf;
      end

      if (cmd.respond) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.saturated   = sat_ff;
         rsp_item_in.index_error = range_ff;
         case (rsrc_ff)
            RSRC_MEM:  rsp_item_in.read_value = mem_rd;
            RSRC_COST: rsp_item_in.read_value = cost_ff;
            default:   rsp_item_in.read_value = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff       <= DEGREE_RESET;
         knots_ff     <= KNOTS_RESET;
         cost_only_ff <= 1'b0;
         pos_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         cost_ff      <= '0;
         sat_ff       <= 1'b0;
         range_ff     <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         deg_ff       <= deg_in;
         knots_ff     <= knots_in;
         cost_only_ff <= cost_only_in;
         pos_ff       <= pos_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cost_ff      <= cost_in;
         sat_ff       <= sat_in;
         range_ff     <= range_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      addr_a_ff   <= addr_a_in;
      addr_b_ff   <= addr_b_in;
      tgt_hess_ff <= tgt_hess_in;
      dual_ff     <= dual_in;
      rsrc_ff     <= rsrc_in;
      rsp_item_ff <= rsp_item_in;
   end

   // memory ports: clearing sweep has priority, else the planned read-modify-write
   assign mem_wdata  = cmd.clear_step ? '0 : mem_add.sum;
   assign hess_we    = cmd.clear_step || (tgt_hess_ff && (cmd.write_a || cmd.write_b));
   assign hess_waddr = cmd.clear_step ? clr_ff : (cmd.write_b ? addr_b_ff : addr_a_ff);
   assign hess_raddr = cmd.rd_b ? addr_b_ff : addr_a_ff;
   assign grad_we    = (cmd.clear_step && int'(clr_ff) < GSTRIDE)
                       || (!tgt_hess_ff && cmd.write_a);
   assign grad_waddr = cmd.clear_step ? clr_ff[GADDR_W-1:0] : addr_a_ff[GADDR_W-1:0];

   shsa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (HESS_DEPTH)
   ) u_hess_ram (
      .clock   (clock),
      .wr_en   (hess_we),
      .wr_addr (hess_waddr),
      .wr_data (mem_wdata),
      .rd_addr (hess_raddr),
      .rd_data (hess_rd)
   );

   shsa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (GSTRIDE)
   ) u_grad_ram (
      .clock   (clock),
      .wr_en   (grad_we),
      .wr_addr (grad_waddr),
      .wr_data (mem_wdata),
      .rd_addr (addr_a_ff[GADDR_W-1:0]),
      .rd_data (grad_rd)
   );

   assign status.act        = act;
   assign status.dual       = dual_ff;
   assign status.clear_done = (clr_ff == HADDR_W'(HESS_DEPTH - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: src/spline_hessian_scatter_accumulator_top.sv
`timescale 1ns / 1ps
// top level of the spline Hessian scatter accumulator
//
//   channel  ports                          direction  transfer
//   req      start, busy, req_item          in         start high while busy low
//   rsp      rsp_valid, rsp_item            out        one-cycle strobe, no backpressure
//   csr      csr_we, csr_index, csr_wdata   in         write when csr_we high
//
// one transaction at a time; after accept the block decodes, then returns to idle for
// a cost word, a dropped word or an ignored code, does one read-modify-write for a
// gradient or diagonal Hessian word and two for an off-diagonal Hessian word (through
// the single Hessian write port, read data registered); a read fetches its value and
// strobes rsp_valid as busy falls.
// reset sweeps the Hessian memory to zero with busy high; clear-all holds busy
// through decode, then the same sweep.
// synchronous active-high reset; csr writes are taken at any time.
module spline_hessian_scatter_accumulator_top import shsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   output rsp_item_type         rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   shsa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   shsa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: src/shsa_checker.sv
`timescale 1ns / 1ps
// port-level checker for the accumulator top, bound onto every instance
module shsa_checker import shsa_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   logic accept;
   logic is_read;

   assign accept  = start && !busy;
   assign is_read = (req_item.req_type == REQ_READ_HESS)
                    || (req_item.req_type == REQ_READ_GRAD)
                    || (req_item.req_type == REQ_READ_COST);

   // every accepted transaction keeps the block busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after an accepted transaction");

   // every accepted read is answered with a rsp_valid strobe
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      accept && is_read |-> ##4 rsp_valid)
      else $error("read transaction gave no result on time");

   // clears, accumulates and unused codes never produce a result; a strobe in the
   // cycle of accept still belongs to a read taken before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      accept && !is_read |-> ##2 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result without a read transaction");

   // a result is shown only once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

endmodule

bind spline_hessian_scatter_accumulator_top shsa_checker u_shsa_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the spline Hessian scatter accumulator
module testbench;
   import shsa_pkg::*;

   localparam int HALF_PERIOD      = 10;
   localparam int RESET_CYCLES     = 7;
   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_LIMIT      = 200;
   localparam int CYCLE_LIMIT      = 1500000;
   localparam int RANDOM_ITEMS     = 1850;
   localparam int FRAME_UNBOUNDED  = 100000;
   localparam int FIRST_UNUSED_REQ = int'(REQ_READ_COST) + 1;
   localparam int LAST_REQ         = (1 << REQ_W) - 1;
   localparam int ROW_SPAN         = 1 << RC_W;
   localparam int START_TOP        = (1 << START_W) - 1;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_item_type         req_item;
   logic                 rsp_valid;
   rsp_item_type         rsp_item;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   // mirror of the accumulator state and its registers
   logic [DATA_W-1:0] hess_mirror [HESS_DEPTH];
   logic [DATA_W-1:0] grad_mirror [GSTRIDE];
   logic [DATA_W-1:0] cost_mirror;
   int                frame_pos;
   int                tri_row;
   int                tri_col;
   bit                clip_seen;
   bit                drop_seen;
   logic [DEG_W-1:0]  degree_reg;
   logic [KNOT_W-1:0] knots_reg;
   logic              cost_only_reg;

   rsp_item_type pending_reads[$];
   rsp_item_type want;
   int           errors = 0;
   int           cycles = 0;
   int           work_items;
   bit           steady;

   spline_hessian_scatter_accumulator_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_reads.size() == 0) begin
            $error("rsp transaction with no read outstanding");
            errors++;
         end else begin
            want = pending_reads.pop_front();
            if (rsp_item.read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_item.read_value);
               errors++;
            end
            if (rsp_item.saturated !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, rsp_item.saturated);
               errors++;
            end
            if (rsp_item.index_error !== want.index_error) begin
               $error("index_error: expected %b, got %b", want.index_error,
                      rsp_item.index_error);
               errors++;
            end
         end
      end
   end

   function automatic int order_in_use();
      if (degree_reg == '0) begin
         return 1;
      end
      if (int'(degree_reg) > MAX_DEGREE) begin
         return MAX_DEGREE;
      end
      return int'(degree_reg);
   endfunction

   function automatic int knots_in_use();
      if (knots_reg == '0) begin
         return 1;
      end
      if (int'(knots_reg) > MAX_KNOTS) begin
         return MAX_KNOTS;
      end
      return int'(knots_reg);
   endfunction

   // translation half sits at the frame's knots, rotation half after all translations
   function automatic int global_slot(int j, int k, int kn, int base_knot);
      if (j < 3 * k) begin
         return 3 * base_knot + j;
      end
      return 3 * (kn + base_knot) + j - 3 * k;
   endfunction

   function automatic logic [DATA_W-1:0] clip_add(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W:0] wide;
      wide = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (wide[DATA_W] != wide[DATA_W-1]) begin
         clip_seen = 1'b1;
         return wide[DATA_W] ? DATA_MIN : DATA_MAX;
      end
      return wide[DATA_W-1:0];
   endfunction

   function automatic void wipe_mirror();
      foreach (hess_mirror[i]) begin
         hess_mirror[i] = '0;
      end
      foreach (grad_mirror[i]) begin
         grad_mirror[i] = '0;
      end
      cost_mirror = '0;
      frame_pos   = 0;
      tri_row     = 0;
      tri_col     = 0;
      clip_seen   = 1'b0;
      drop_seen   = 1'b0;
   endfunction

   function automatic void accumulate_word(logic [DATA_W-1:0] value, int base_knot);
      int k;
      int kn;
      int n;
      int g;
      int flen;
      int r;
      int c;
      k    = order_in_use();
      kn   = knots_in_use();
      n    = 6 * k;
      g    = 6 * kn;
      flen = (n + 1) * (n + 2) / 2;
      // a shorter frame after a degree change restarts on the cost word
      if (frame_pos >= flen) begin
         frame_pos = 0;
      end
      if (frame_pos == 0) begin
         cost_mirror = clip_add(cost_mirror, value);
         tri_row     = 0;
         tri_col     = 0;
      end else if (frame_pos <= n) begin
         if (!cost_only_reg) begin
            r = global_slot(frame_pos - 1, k, kn, base_knot);
            if (r < g) begin
               grad_mirror[r] = clip_add(grad_mirror[r], value);
            end else begin
               drop_seen = 1'b1;
            end
         end
      end else begin
         if (!cost_only_reg) begin
            if (tri_row >= n || tri_col >= n) begin
               drop_seen = 1'b1;
            end else begin
               r = global_slot(tri_row, k, kn, base_knot);
               c = global_slot(tri_col, k, kn, base_knot);
               if (r < g && c < g) begin
                  hess_mirror[r * GSTRIDE + c] = clip_add(hess_mirror[r * GSTRIDE + c], value);
                  if (r != c) begin
                     hess_mirror[c * GSTRIDE + r] = clip_add(hess_mirror[c * GSTRIDE + r],
                                                             value);
                  end
               end else begin
                  drop_seen = 1'b1;
               end
            end
         end
         tri_col++;
         if (tri_col >= n) begin
            tri_row++;
            tri_col = tri_row;
         end
      end
      frame_pos++;
      if (frame_pos >= flen) begin
         frame_pos = 0;
      end
   endfunction

   function automatic void predict(req_item_type it);
      rsp_item_type r;
      int           g;
      int           row;
      int           col;
      g             = 6 * knots_in_use();
      row           = int'(it.read_row);
      col           = int'(it.read_col);
      r.read_value  = '0;
      r.saturated   = 1'b0;
      r.index_error = 1'b0;
      case (it.req_type)
         REQ_CLEAR: begin
            wipe_mirror();
         end
         REQ_ACCUM: begin
            accumulate_word(it.word_value, int'(it.start_knot));
         end
         REQ_READ_HESS, REQ_READ_GRAD, REQ_READ_COST: begin
            if (it.req_type == REQ_READ_COST) begin
               r.read_value = cost_mirror;
            end else if (it.req_type == REQ_READ_GRAD) begin
               if (row < g) begin
                  r.read_value = grad_mirror[row];
               end
            end else if (row < g && col < g) begin
               r.read_value = hess_mirror[row * GSTRIDE + col];
            end
            r.saturated   = clip_seen;
            r.index_error = drop_seen;
            pending_reads.push_back(r);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic req_item_type make_req(logic [REQ_W-1:0] code, logic [DATA_W-1:0] value,
                                             int base_knot, int row, int col);
      req_item_type it;
      it.req_type   = code;
      it.word_value = value;
      it.start_knot = START_W'(base_knot);
      it.read_row   = RC_W'(row);
      it.read_col   = RC_W'(col);
      return it;
   endfunction

   function automatic logic [DATA_W-1:0] random_word();
      logic [DATA_W-1:0] v;
      int                pick;
      pick = $urandom_range(0, 99);
      v    = {$urandom, $urandom};
      if (pick < 75) begin
         v = {{(DATA_W - 36){v[35]}}, v[35:0]};
      end else if (pick < 80) begin
         v = DATA_MAX - DATA_W'($urandom_range(0, 3));
      end else if (pick < 85) begin
         v = DATA_MIN + DATA_W'($urandom_range(0, 3));
      end
      return v;
   endfunction

   function automatic int pick_start(int k, int kn);
      if ($urandom_range(0, 4) == 0 || kn < k) begin
         return $urandom_range(0, START_TOP);
      end
      return $urandom_range(0, (kn - k > START_TOP) ? START_TOP : kn - k);
   endfunction

   function automatic void reset_mirror();
      wipe_mirror();
      degree_reg    = DEGREE_RESET;
      knots_reg     = KNOTS_RESET;
      cost_only_reg = 1'b0;
   endfunction

   // start stays high across back-to-back transactions
   task automatic issue(req_item_type it);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 40) begin
         gap = $urandom_range(1, 5);
      end
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do begin
         @(posedge clock);
      end while (busy);
      predict(it);
      if (it.req_type <= REQ_READ_COST) begin
         work_items++;
      end
   endtask

   task automatic send_word(logic [DATA_W-1:0] value, int base_knot);
      issue(make_req(REQ_ACCUM, value, base_knot, $urandom_range(0, ROW_SPAN - 1),
                     $urandom_range(0, ROW_SPAN - 1)));
   endtask

   task automatic read_entry(req_code_type code, int row, int col);
      issue(make_req(code, {$urandom, $urandom}, $urandom_range(0, START_TOP), row, col));
   endtask

   task automatic send_unused(int code);
      issue(make_req(REQ_W'(code), {$urandom, $urandom}, $urandom_range(0, START_TOP),
                     $urandom_range(0, ROW_SPAN - 1), $urandom_range(0, ROW_SPAN - 1)));
   endtask

   task automatic clear_all_stores();
      issue(make_req(REQ_CLEAR, {$urandom, $urandom}, $urandom_range(0, START_TOP),
                     $urandom_range(0, ROW_SPAN - 1), $urandom_range(0, ROW_SPAN - 1)));
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEGREE: begin
            degree_reg = value[DEG_W-1:0];
         end
         CSR_KNOTS: begin
            knots_reg = value[KNOT_W-1:0];
         end
         CSR_COST_ONLY: begin
            cost_only_reg = value[0];
         end
         default: begin
         end
      endcase
   endtask

   // lets every read come back and the block fall idle before a register write
   task automatic drain();
      int waited;
      @(negedge clock);
      start  <= 1'b0;
      waited = 0;
      while (pending_reads.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_reads.size() != 0) begin
         $error("%0d read transactions never answered", pending_reads.size());
         errors++;
         pending_reads.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic read_somewhere(int base_knot);
      int k;
      int kn;
      int row;
      int col;
      int pick;
      k   = order_in_use();
      kn  = knots_in_use();
      row = global_slot($urandom_range(0, 6 * k - 1), k, kn, base_knot);
      col = global_slot($urandom_range(0, 6 * k - 1), k, kn, base_knot);
      if ($urandom_range(0, 3) == 0) begin
         row = $urandom_range(0, ROW_SPAN - 1);
      end
      if ($urandom_range(0, 3) == 0) begin
         col = $urandom_range(0, ROW_SPAN - 1);
      end
      pick = $urandom_range(0, 5);
      if (pick < 3) begin
         read_entry(REQ_READ_HESS, row, col);
      end else if (pick < 5) begin
         read_entry(REQ_READ_GRAD, row, col);
      end else begin
         read_entry(REQ_READ_COST, row, col);
      end
   endtask

   task automatic maybe_interject(int base_knot);
      int pick;
      pick = $urandom_range(0, 999);
      if (pick < 80) begin
         read_somewhere(base_knot);
      end else if (pick < 100) begin
         send_unused($urandom_range(FIRST_UNUSED_REQ, LAST_REQ));
      end else if (pick < 102) begin
         clear_all_stores();
      end
   endtask

   // words until the frame wraps around, or until limit words went out
   task automatic send_frame(int base_knot, int limit);
      int sent;
      sent = 0;
      do begin
         maybe_interject(base_knot);
         send_word(random_word(), base_knot);
         sent++;
      end while (frame_pos != 0 && sent < limit);
   endtask

   task automatic pick_settings();
      logic [CSR_W-1:0] v;
      int               pick;
      pick = $urandom_range(0, 19);
      v    = CSR_W'($urandom);
      if (pick == 0) begin
         v[DEG_W-1:0] = '0;
      end else if (pick < 10) begin
         v[DEG_W-1:0] = DEG_W'(1);
      end else if (pick < 15) begin
         v[DEG_W-1:0] = DEG_W'(2);
      end else if (pick < 17) begin
         v[DEG_W-1:0] = DEG_W'(3);
      end else if (pick == 17) begin
         v[DEG_W-1:0] = DEG_W'(MAX_DEGREE);
      end else begin
         v[DEG_W-1:0] = DEG_W'($urandom_range(MAX_DEGREE + 1, (1 << DEG_W) - 1));
      end
      write_reg(CSR_DEGREE, v);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         v = '0;
      end else if (pick == 1) begin
         v = CSR_W'(1);
      end else if (pick == 2) begin
         v = CSR_W'(MAX_KNOTS);
      end else if (pick == 3) begin
         v = CSR_W'($urandom_range(MAX_KNOTS + 1, (1 << KNOT_W) - 1));
      end else begin
         v = CSR_W'($urandom_range(2, MAX_KNOTS));
      end
      write_reg(CSR_KNOTS, v);
      v    = CSR_W'($urandom);
      v[0] = ($urandom_range(0, 4) == 0);
      write_reg(CSR_COST_ONLY, v);
   endtask

   task automatic test_idle_reads();
      read_entry(REQ_READ_COST, 0, 0);
      read_entry(REQ_READ_GRAD, ROW_SPAN - 1, 0);
      read_entry(REQ_READ_HESS, GSTRIDE - 1, ROW_SPAN - 1);
      read_entry(REQ_READ_HESS, ROW_SPAN - 1, ROW_SPAN - 1);
      for (int code = FIRST_UNUSED_REQ; code <= LAST_REQ; code++) begin
         send_unused(code);
      end
      read_entry(REQ_READ_GRAD, 0, 0);
   endtask

   task automatic test_extreme_frame();
      drain();
      write_reg(CSR_DEGREE, CSR_W'(1));
      write_reg(CSR_KNOTS, CSR_W'(1));
      write_reg(CSR_COST_ONLY, '0);
      send_word(DATA_MAX, 0);
      send_word(DATA_MIN, 0);
      send_word(DATA_MAX, 0);
      send_word('1, 0);
      send_word(DATA_W'(1), 0);
      send_word('0, 0);
      send_word({$urandom, $urandom}, 0);
      send_word(DATA_MAX, 0);
      send_word(DATA_MIN, 0);
      repeat (19) send_word(random_word(), 0);
      // second frame opens on the cost, which clips now
      send_word(DATA_MAX, 0);
      read_entry(REQ_READ_COST, 0, 0);
      read_entry(REQ_READ_GRAD, 0, 0);
      read_entry(REQ_READ_HESS, 0, 1);
      read_entry(REQ_READ_HESS, 1, 0);
      read_entry(REQ_READ_HESS, 0, 6);
   endtask

   task automatic test_register_clamps();
      drain();
      write_reg(CSR_KNOTS, '0);
      read_entry(REQ_READ_HESS, 1, 0);
      read_entry(REQ_READ_GRAD, 6, 0);
      drain();
      write_reg(CSR_KNOTS, CSR_W'(20));
      read_entry(REQ_READ_GRAD, 0, 0);
      drain();
      write_reg(CSR_DEGREE, '0);
      write_reg(CSR_COST_ONLY, CSR_W'(1));
      repeat (3) send_word(random_word(), 0);
      read_entry(REQ_READ_GRAD, 1, 0);
      read_entry(REQ_READ_COST, 0, 0);
      drain();
      write_reg(CSR_COST_ONLY, '0);
      write_reg(CSR_DEGREE, CSR_W'(7));
      write_reg(CSR_KNOTS, CSR_W'(31));
      repeat (3) send_word(random_word(), START_TOP);
      read_entry(REQ_READ_GRAD, global_slot(3, MAX_DEGREE, MAX_KNOTS, START_TOP), 0);
      clear_all_stores();
      read_entry(REQ_READ_COST, 0, 0);
   endtask

   task automatic test_degree_change();
      drain();
      write_reg(CSR_KNOTS, CSR_W'(MAX_KNOTS));
      write_reg(CSR_DEGREE, CSR_W'(2));
      repeat (19) send_word(random_word(), 0);
      // the shorter frame finds the triangle column already past its size
      drain();
      write_reg(CSR_DEGREE, CSR_W'(1));
      repeat (2) send_word(random_word(), 0);
      read_entry(REQ_READ_COST, 0, 0);
      drain();
      write_reg(CSR_DEGREE, CSR_W'(2));
      repeat (9) send_word(random_word(), 1);
      // position now lies past the end of a degree-one frame
      drain();
      write_reg(CSR_DEGREE, CSR_W'(1));
      send_word(DATA_MAX, 0);
      read_entry(REQ_READ_COST, 0, 0);
      read_entry(REQ_READ_HESS, 3, 4);
   endtask

   task automatic test_random_frames();
      int phase;
      int k;
      int kn;
      int flen;
      int base_knot;
      phase      = 0;
      base_knot  = 0;
      work_items = 0;
      while (work_items < RANDOM_ITEMS) begin
         drain();
         steady = (phase % 5 == 2);
         pick_settings();
         if ($urandom_range(0, 3) == 0) begin
            clear_all_stores();
         end
         k    = order_in_use();
         kn   = knots_in_use();
         flen = (6 * k + 1) * (6 * k + 2) / 2;
         repeat ((k >= 3) ? 1 : $urandom_range(1, 3)) begin
            base_knot = pick_start(k, kn);
            send_frame(base_knot, FRAME_UNBOUNDED);
         end
         // a frame left partway carries over into the next settings
         if ($urandom_range(0, 1) == 0) begin
            base_knot = pick_start(k, kn);
            send_frame(base_knot, $urandom_range(1, flen - 1));
         end
         repeat ($urandom_range(4, 10)) read_somewhere(base_knot);
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_DEGREE;
      csr_wdata  = '0;
      steady     = 1'b0;
      work_items = 0;
      reset_mirror();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_idle_reads();
      test_extreme_frame();
      test_register_clamps();
      test_degree_change();
      test_random_frames();
      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
src/shsa_pkg.sv
src/shsa_ram.sv
src/shsa_ctrl.sv
src/shsa_dp.sv
src/spline_hessian_scatter_accumulator_top.sv
src/shsa_checker.sv
tb/testbench.sv
